### hw/rtl/http_response_header_parser_top_assert.svh
// Assertion macros for the response header parser.
`ifndef HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH
`define HTTP_RESPONSE_HEADER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define HRHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define HRHP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hrhp_pkg.sv
package hrhp_pkg;

    localparam int BYTE_W      = 8;
    localparam int REQ_W       = 2;
    localparam int HDR_LIMIT_W = 14;
    localparam int STATUS_W    = 3;
    localparam int BODY_LEFT_W = 32;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 4;
    localparam int OUT_PAD_W   = OUT_TDATA_W - BYTE_W - BODY_LEFT_W - 1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEADER_LIMIT   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FORWARD_HEADER = 1'd1;
    localparam logic [HDR_LIMIT_W-1:0] HEADER_LIMIT_RESET = 14'd8192;

    localparam logic [REQ_W-1:0] REQ_DATA        = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PEER_CLOSED = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START       = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HEADER = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BODY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ERROR  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLOSED = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF      = 8'h0a;
    localparam logic [BYTE_W-1:0] CHAR_VT      = 8'h0b;
    localparam logic [BYTE_W-1:0] CHAR_FF      = 8'h0c;
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2b;
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_COLON   = 8'h3a;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_C = 8'h43;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    localparam int KEY_LEN_CHARS  = 14;
    localparam int KEY_CONN_CHARS = 10;
    localparam int CLOSE_CHARS    = 5;
    localparam logic [KEY_LEN_CHARS*BYTE_W-1:0]  KEY_LEN_TEXT  = "content-length";
    localparam logic [KEY_CONN_CHARS*BYTE_W-1:0] KEY_CONN_TEXT = "connection";
    localparam logic [CLOSE_CHARS*BYTE_W-1:0]    CLOSE_TEXT    = "close";
    localparam logic [2:0] CLOSE_FAIL = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DONE,
        PH_CLOSED
    } phase_t;

    typedef enum logic [2:0] {
        LP_LEAD,
        LP_NAME,
        LP_TRAIL,
        LP_VLEAD,
        LP_SIGN,
        LP_DIGITS,
        LP_SKIP
    } line_phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LEN,
        KIND_CONN
    } line_kind_t;

    // One input transaction after classification.
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [BYTE_W-1:0] chr;
        logic [BYTE_W-1:0] lc;
        logic [3:0]        digit;
        logic              is_blank;
        logic              is_cr;
        logic              is_lf;
        logic              is_colon;
        logic              is_digit;
        logic              is_len_space;
        logic              is_plus;
        logic              is_minus;
    } byte_class_t;

    function automatic byte_class_t classify(logic [REQ_W-1:0] req, logic [BYTE_W-1:0] chr);
        byte_class_t k;
        k.req          = req;
        k.chr          = chr;
        k.lc           = (chr >= CHAR_UPPER_A && chr <= CHAR_UPPER_Z) ? chr + CASE_OFFSET : chr;
        k.is_digit     = (chr >= CHAR_ZERO && chr <= CHAR_NINE);
        k.digit        = k.is_digit ? 4'(chr - CHAR_ZERO) : 4'd0;
        k.is_blank     = (chr == CHAR_SPACE) || (chr == CHAR_TAB);
        k.is_cr        = (chr == CHAR_CR);
        k.is_lf        = (chr == CHAR_LF);
        k.is_colon     = (chr == CHAR_COLON);
        k.is_len_space = k.is_blank || k.is_cr || k.is_lf || (chr == CHAR_VT) || (chr == CHAR_FF);
        k.is_plus      = (chr == CHAR_PLUS);
        k.is_minus     = (chr == CHAR_MINUS);
        return k;
    endfunction

    function automatic logic [BYTE_W-1:0] key_len_char(logic [3:0] pos);
        logic [BYTE_W-1:0] c;
        c = '0;
        if (int'(pos) < KEY_LEN_CHARS)
        begin
            c = KEY_LEN_TEXT[(KEY_LEN_CHARS - 1 - int'(pos)) * BYTE_W +: BYTE_W];
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] key_conn_char(logic [3:0] pos);
        logic [BYTE_W-1:0] c;
        c = '0;
        if (int'(pos) < KEY_CONN_CHARS)
        begin
            c = KEY_CONN_TEXT[(KEY_CONN_CHARS - 1 - int'(pos)) * BYTE_W +: BYTE_W];
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] close_char(logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        c = '0;
        if (int'(pos) < CLOSE_CHARS)
        begin
            c = CLOSE_TEXT[(CLOSE_CHARS - 1 - int'(pos)) * BYTE_W +: BYTE_W];
        end
        return c;
    endfunction

endpackage

### hw/rtl/hrhp_front.sv
module hrhp_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hrhp_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  logic [hrhp_pkg::IN_TUSER_W-1:0]    s_tuser,   // [1:0] req_kind
    input  logic                               q_full,
    output logic                               push,
    output hrhp_pkg::byte_class_t              push_data
);
    import hrhp_pkg::*;

    // Take a transaction whenever the queue has room; classify on the way in.
    assign s_tready  = !q_full;
    assign push      = s_tvalid && !q_full;
    assign push_data = classify(s_tuser, s_tdata);

endmodule

### hw/rtl/hrhp_queue.sv
module hrhp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hrhp_pkg::byte_class_t push_data,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output hrhp_pkg::byte_class_t pop_data
);
    import hrhp_pkg::*;

    byte_class_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]      wr_ptr_reg;
    logic [QUEUE_AW-1:0]      rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic                     do_push;
    logic                     do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/hrhp_back.sv
module hrhp_back #(
    parameter int MAX_HEADER  = 8192,
    parameter int LENGTH_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hrhp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hrhp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_valid,
    input  hrhp_pkg::byte_class_t               q_data,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [hrhp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [hrhp_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import hrhp_pkg::*;

    localparam int CNT_W = $clog2(MAX_HEADER + 1);
    localparam int CMP_W = (CNT_W > HDR_LIMIT_W) ? CNT_W : HDR_LIMIT_W;
    localparam int ACC_W = LENGTH_BITS + 4;
    localparam logic [CMP_W-1:0] MAX_HEADER_C = CMP_W'(MAX_HEADER);
    localparam byte_class_t CR_CLASS = classify(REQ_DATA, CHAR_CR);

    typedef struct packed {
        line_phase_t            lp;
        logic [3:0]             pos;
        logic [1:0]             cand;
        line_kind_t             kind;
        logic [LENGTH_BITS-1:0] accum;
        logic                   neg;
        logic [2:0]             cpos;
    } line_t;

    function automatic line_t line_init();
        line_t r;
        r.lp    = LP_LEAD;
        r.pos   = '0;
        r.cand  = 2'b11;
        r.kind  = KIND_NONE;
        r.accum = '0;
        r.neg   = 1'b0;
        r.cpos  = '0;
        return r;
    endfunction

    function automatic line_t name_char(line_t s, byte_class_t k);
        line_t r;
        r = s;
        if (int'(s.pos) < KEY_LEN_CHARS)
        begin
            if (key_len_char(s.pos) != k.lc)
            begin
                r.cand[0] = 1'b0;
            end
            if (int'(s.pos) >= KEY_CONN_CHARS || key_conn_char(s.pos) != k.lc)
            begin
                r.cand[1] = 1'b0;
            end
            r.pos = s.pos + 4'd1;
        end
        else
        begin
            r.cand = 2'b00;
        end
        return r;
    endfunction

    function automatic line_t to_value(line_t s);
        line_t r;
        r      = s;
        r.kind = KIND_NONE;
        if (s.cand[0] && int'(s.pos) == KEY_LEN_CHARS)
        begin
            r.kind = KIND_LEN;
        end
        else if (s.cand[1] && int'(s.pos) == KEY_CONN_CHARS)
        begin
            r.kind = KIND_CONN;
        end
        r.lp    = LP_VLEAD;
        r.accum = '0;
        r.neg   = 1'b0;
        r.cpos  = '0;
        return r;
    endfunction

    // Times ten plus digit; saturate when the product spills past LENGTH_BITS.
    function automatic logic [LENGTH_BITS-1:0] add_digit(logic [LENGTH_BITS-1:0] acc,
                                                         logic [3:0] d);
        logic [ACC_W-1:0] p;
        logic [LENGTH_BITS-1:0] r;
        p = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(d);
        if (p[ACC_W-1 -: 4] != 4'd0)
        begin
            r = '1;
        end
        else
        begin
            r = p[LENGTH_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] match_close(logic [2:0] cpos, logic [BYTE_W-1:0] chr);
        logic [2:0] r;
        if (int'(cpos) >= CLOSE_CHARS)
        begin
            r = CLOSE_FAIL;
        end
        else if (chr == close_char(cpos) || (cpos == 3'd0 && chr == CHAR_UPPER_C))
        begin
            r = cpos + 3'd1;
        end
        else
        begin
            r = CLOSE_FAIL;
        end
        return r;
    endfunction

    function automatic line_t feed(line_t s, byte_class_t k);
        line_t r;
        r = s;
        unique case (s.lp)
            LP_LEAD:
            begin
                if (k.is_colon)
                begin
                    r = to_value(s);
                end
                else if (!k.is_blank)
                begin
                    r    = name_char(s, k);
                    r.lp = LP_NAME;
                end
            end
            LP_NAME:
            begin
                if (k.is_blank)
                begin
                    r.lp = LP_TRAIL;
                end
                else if (k.is_colon)
                begin
                    r = to_value(s);
                end
                else
                begin
                    r = name_char(s, k);
                end
            end
            LP_TRAIL:
            begin
                if (k.is_colon)
                begin
                    r = to_value(s);
                end
                else if (!k.is_blank)
                begin
                    r.cand = 2'b00;
                    r.lp   = LP_NAME;
                end
            end
            LP_VLEAD:
            begin
                if (s.kind == KIND_LEN)
                begin
                    if (!k.is_len_space)
                    begin
                        if (k.is_plus)
                        begin
                            r.lp = LP_SIGN;
                        end
                        else if (k.is_minus)
                        begin
                            r.neg = 1'b1;
                            r.lp  = LP_SIGN;
                        end
                        else if (k.is_digit)
                        begin
                            r.accum = add_digit(s.accum, k.digit);
                            r.lp    = LP_DIGITS;
                        end
                        else
                        begin
                            r.lp = LP_SKIP;
                        end
                    end
                end
                else if (s.kind == KIND_CONN)
                begin
                    if (!k.is_blank)
                    begin
                        r.lp   = LP_DIGITS;
                        r.cpos = match_close(s.cpos, k.chr);
                    end
                end
                else
                begin
                    r.lp = LP_SKIP;
                end
            end
            LP_SIGN:
            begin
                if (k.is_digit)
                begin
                    r.accum = add_digit(s.accum, k.digit);
                    r.lp    = LP_DIGITS;
                end
                else
                begin
                    r.lp = LP_SKIP;
                end
            end
            LP_DIGITS:
            begin
                if (s.kind == KIND_LEN)
                begin
                    if (k.is_digit)
                    begin
                        r.accum = add_digit(s.accum, k.digit);
                    end
                    else
                    begin
                        r.lp = LP_SKIP;
                    end
                end
                else
                begin
                    r.cpos = match_close(s.cpos, k.chr);
                end
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

    logic [HDR_LIMIT_W-1:0]   header_limit_reg;
    logic                     forward_header_reg;

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [1:0]               term_reg;
    logic [1:0]               term_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    line_t                    line_reg;
    line_t                    line_next;
    line_t                    line_cr;
    logic                     seen_reg;
    logic                     seen_next;
    logic [LENGTH_BITS-1:0]   remaining_reg;
    logic [LENGTH_BITS-1:0]   remaining_next;
    logic                     close_reg;
    logic                     close_next;
    logic                     error_reg;
    logic                     error_next;

    logic [CMP_W-1:0]         limit_ext;
    logic                     over_limit;
    logic                     byte_valid;
    logic [BYTE_W-1:0]        byte_out;
    logic [STATUS_W-1:0]      status_next;

    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   tdata_reg;
    logic [OUT_TUSER_W-1:0]   tuser_reg;

    assign q_pop    = q_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    assign limit_ext  = (CMP_W'(header_limit_reg) < MAX_HEADER_C) ?
                        CMP_W'(header_limit_reg) : MAX_HEADER_C;
    assign over_limit = (CMP_W'(count_reg) >= limit_ext);

    always_comb
    begin
        phase_next     = phase_reg;
        term_next      = term_reg;
        count_next     = count_reg;
        line_next      = line_reg;
        seen_next      = seen_reg;
        remaining_next = remaining_reg;
        close_next     = close_reg;
        error_next     = error_reg;
        byte_valid     = 1'b0;
        byte_out       = '0;
        line_cr        = feed(line_reg, CR_CLASS);

        priority if (q_data.req == REQ_START)
        begin
            phase_next     = PH_HEADER;
            term_next      = '0;
            count_next     = '0;
            line_next      = line_init();
            seen_next      = 1'b0;
            remaining_next = '0;
            close_next     = 1'b0;
            error_next     = 1'b0;
        end
        else if (q_data.req == REQ_PEER_CLOSED)
        begin
            phase_next = PH_CLOSED;
        end
        else if (q_data.req == REQ_DATA && phase_reg != PH_CLOSED && !error_reg)
        begin
            if (phase_reg == PH_HEADER)
            begin
                if (over_limit)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (forward_header_reg)
                    begin
                        byte_valid = 1'b1;
                        byte_out   = q_data.chr;
                    end
                    if (term_reg[0])
                    begin
                        // A CR is pending: LF ends the line, anything else makes it text.
                        if (q_data.is_lf)
                        begin
                            if (line_reg.kind == KIND_LEN && line_reg.lp >= LP_VLEAD)
                            begin
                                if (line_reg.neg && line_reg.accum != '0)
                                begin
                                    seen_next      = 1'b0;
                                    remaining_next = '0;
                                end
                                else
                                begin
                                    seen_next      = 1'b1;
                                    remaining_next = line_reg.accum;
                                end
                            end
                            else if (line_reg.kind == KIND_CONN &&
                                     int'(line_reg.cpos) == CLOSE_CHARS)
                            begin
                                close_next = 1'b1;
                            end
                            line_next = line_init();
                            if (term_reg == 2'd3)
                            begin
                                term_next = '0;
                                if (!seen_next)
                                begin
                                    error_next = 1'b1;
                                end
                                else
                                begin
                                    phase_next = (remaining_next == '0) ? PH_DONE : PH_BODY;
                                end
                            end
                            else
                            begin
                                term_next = 2'd2;
                            end
                        end
                        else if (q_data.is_cr)
                        begin
                            term_next = 2'd1;
                            line_next = line_cr;
                        end
                        else
                        begin
                            term_next = '0;
                            line_next = feed(line_cr, q_data);
                        end
                    end
                    else if (q_data.is_cr)
                    begin
                        term_next = term_reg + 2'd1;
                    end
                    else
                    begin
                        term_next = '0;
                        line_next = feed(line_reg, q_data);
                    end
                end
            end
            else if (phase_reg == PH_BODY)
            begin
                byte_valid = 1'b1;
                byte_out   = q_data.chr;
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - LENGTH_BITS'(1);
                end
                if (remaining_next == '0)
                begin
                    phase_next = PH_DONE;
                end
            end
        end
        else
        begin
            // Unused request kind, or a data byte while closed or in error: hold state.
        end

        priority if (phase_next == PH_CLOSED)
        begin
            status_next = ST_CLOSED;
        end
        else if (error_next)
        begin
            status_next = ST_ERROR;
        end
        else
        begin
            unique case (phase_next)
                PH_HEADER: status_next = ST_HEADER;
                PH_BODY:   status_next = ST_BODY;
                default:   status_next = ST_DONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_limit_reg   <= HEADER_LIMIT_RESET;
            forward_header_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_HEADER_LIMIT:   header_limit_reg   <= cfg_data[HDR_LIMIT_W-1:0];
                CFG_FORWARD_HEADER: forward_header_reg <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            term_reg      <= '0;
            count_reg     <= '0;
            line_reg      <= line_init();
            seen_reg      <= 1'b0;
            remaining_reg <= '0;
            close_reg     <= 1'b0;
            error_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                term_reg      <= term_next;
                count_reg     <= count_next;
                line_reg      <= line_next;
                seen_reg      <= seen_next;
                remaining_reg <= remaining_next;
                close_reg     <= close_next;
                error_reg     <= error_next;
                m_tvalid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tdata_reg <= {OUT_PAD_W'(0), close_next, BODY_LEFT_W'(remaining_next), byte_out};
            tuser_reg <= {byte_valid, status_next};
        end
    end

endmodule

### hw/rtl/http_response_header_parser_top.sv
// HTTP response header parser. Feed the response one byte per transaction on the s_ side
// (the request kind in s_tuser: data byte, peer closed, or start of a new response) and
// take one result transaction on the m_ side for every input transaction, in order. Header
// bytes are counted against header_limit (and never more than MAX_HEADER), split into
// lines at CR LF, and the header ends at CR LF CR LF; a content-length line is decoded in
// decimal (saturating at 2^LENGTH_BITS - 1) and a connection line of close or Close raises
// close_after. With a length the block counts body bytes down to completion; without one
// the response is an error. Error and peer-closed are sticky until the next start. Header
// bytes are forwarded when forward_header is set, body bytes always. Throughput is one
// transaction per clock, sustained, while the output side is not stalling: the front end
// classifies each byte as it is taken, a four-entry queue decouples it from the parser,
// and the parser updates its few state registers for each transaction straight into the
// output register. An accepted input transaction is written into the queue, and its
// result is then registered into the output register, to be taken when the output side
// is not stalling; while the output stalls, up to four more transactions are taken
// before s_tready drops. There is no clearing pass after reset. Write the configuration
// registers only while the block is idle.
module http_response_header_parser_top #(
    parameter int MAX_HEADER  = 8192,
    parameter int LENGTH_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // configuration: index 0 header_limit, index 1 forward_header
    input  logic                               cfg_we,
    input  logic [hrhp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [hrhp_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hrhp_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  logic [hrhp_pkg::IN_TUSER_W-1:0]    s_tuser,   // [1:0] req_kind

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] out_byte, [39:8] body_left, [40] close_after, [47:41] zero
    output logic [hrhp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // [2:0] status, [3] out_valid
    output logic [hrhp_pkg::OUT_TUSER_W-1:0]   m_tuser
);
    import hrhp_pkg::*;

    logic        push;
    byte_class_t push_data;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    byte_class_t q_data;

    // Front end: hold s_tready high while the queue has room, classify each byte.
    hrhp_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    // Short queue: lets the front keep taking bytes while the output stalls.
    hrhp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .empty     (q_empty),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    // Back end: the header and body parser plus the output register.
    hrhp_back #(
        .MAX_HEADER  (MAX_HEADER),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .q_valid  (!q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`include "http_response_header_parser_top_assert.svh"

    // An accepted transaction into an empty queue must be waiting there next cycle.
    `HRHP_ASSERT_NXT(a_accept_lands, s_tvalid && s_tready && q_empty, !q_empty, "accepted transaction lost before the queue")
    // A result without a forwarded byte carries a zero byte.
    `HRHP_ASSERT_IMP(a_idle_byte_zero, m_tvalid && !m_tuser[3], m_tdata[7:0] == 8'd0, "out_byte not zero while out_valid is low")
    // Nothing is forwarded once the peer has closed.
    `HRHP_ASSERT_IMP(a_no_byte_closed, m_tvalid && m_tuser[3], m_tuser[2:0] != ST_CLOSED, "byte forwarded with status peer closed")

endmodule
